// File: sv/triangle_box_overlap_table_assert.svh
// Assertion macros for the triangle table checker
`ifndef TRIANGLE_BOX_OVERLAP_TABLE_ASSERT_SVH
`define TRIANGLE_BOX_OVERLAP_TABLE_ASSERT_SVH

// same-cycle implication
`define TBOT_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tbot assertion failed");

// next-cycle implication
`define TBOT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tbot assertion failed");

`endif

// File: sv/tbot_pkg.sv
package tbot_pkg;

  localparam int unsigned TriangleDepth = 256;
  localparam int unsigned AddrW = (TriangleDepth > 1) ? $clog2(TriangleDepth) : 1;
  localparam int unsigned CntW = $clog2(TriangleDepth + 1);
  localparam int unsigned CoordW = 16;
  localparam int unsigned HalfW = 15;
  localparam int unsigned NormW = 35;
  localparam int unsigned CountOutW = 9;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAdd   = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgHalfWidth  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgHalfHeight = 8'd1;

  localparam logic [HalfW-1:0] HalfWidthRst  = 15'd256;
  localparam logic [HalfW-1:0] HalfHeightRst = 15'd512;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [CoordW-1:0] corner_a_x;
    logic signed [CoordW-1:0] corner_a_y;
    logic signed [CoordW-1:0] corner_a_z;
    logic signed [CoordW-1:0] corner_b_x;
    logic signed [CoordW-1:0] corner_b_y;
    logic signed [CoordW-1:0] corner_b_z;
    logic signed [CoordW-1:0] corner_c_x;
    logic signed [CoordW-1:0] corner_c_y;
    logic signed [CoordW-1:0] corner_c_z;
  } in_word_t;

  typedef struct packed {
    logic                 hit;
    logic                 status;
    logic [CountOutW-1:0] triangle_count;
  } out_word_t;

  typedef logic [2:0][CoordW-1:0] vec3_t;

  typedef struct packed {
    vec3_t                 a;
    vec3_t                 b;
    vec3_t                 c;
    vec3_t                 lo;
    vec3_t                 hi;
    logic [2:0][NormW-1:0] nrm;
  } tri_entry_t;

  localparam int unsigned EntryW = $bits(tri_entry_t);

  typedef struct packed {
    logic             load;
    logic             clr_hit;
    logic             wr_en;
    logic             rd_en;
    logic [AddrW-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } sts_t;

  // next axis index, cyclic over x, y, z
  function automatic int unsigned nxt(input int unsigned k);
    return (k == 2) ? 0 : k + 1;
  endfunction

endpackage

// File: sv/triangle_box_overlap_table.sv
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid_i/in_stall_o | in_word_t: opcode, corners A, B, C
// out     | output    | out_valid_o/out_stall_i | out_word_t: hit, status, triangle_count
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Clear, dropped add, unused opcode and empty-table query go straight to StDone.
// Add: edge registers, then cross-product registers, then one table write in
// StAdd3. Query: one table read per cycle feeds a four-stage test pipeline.
// Reset empties the table at once; the table memory is not cleared.
// A finished word waits in the output register while the next item is taken.
module triangle_box_overlap_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tbot_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tbot_pkg::out_word_t           out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tbot_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tbot_pkg::HalfW-1:0]    cfg_data_i
);

  tbot_pkg::cmd_t cmd;
  tbot_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  tbot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (in_word_i.opcode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tbot_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

// File: sv/tbot_ram.sv
module tbot_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]              wdata_i,
  input  logic                          re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tbot_datapath.sv
module tbot_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbot_pkg::cmd_t                   cmd_i,
  output tbot_pkg::sts_t                   sts_o,
  input  tbot_pkg::in_word_t               in_word_i,
  input  logic                             cfg_valid_i,
  input  logic [tbot_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tbot_pkg::HalfW-1:0]       cfg_data_i
);

  localparam int unsigned CW = tbot_pkg::CoordW;
  localparam int unsigned NW = tbot_pkg::NormW;

  tbot_pkg::in_word_t in_q;
  logic [tbot_pkg::HalfW-1:0] half_w_q, half_h_q;
  logic [tbot_pkg::HalfW-1:0] hv [3];

  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  logic signed [CW-1:0] pc [3];

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_w_q <= tbot_pkg::HalfWidthRst;
      half_h_q <= tbot_pkg::HalfHeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tbot_pkg::CfgHalfWidth:  half_w_q <= cfg_data_i;
        tbot_pkg::CfgHalfHeight: half_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_word_i;
    end
  end

  always_comb begin
    hv[0] = half_w_q;
    hv[1] = half_h_q;
    hv[2] = half_w_q;
    pa[0] = in_q.corner_a_x; pa[1] = in_q.corner_a_y; pa[2] = in_q.corner_a_z;
    pb[0] = in_q.corner_b_x; pb[1] = in_q.corner_b_y; pb[2] = in_q.corner_b_z;
    pc[0] = in_q.corner_c_x; pc[1] = in_q.corner_c_y; pc[2] = in_q.corner_c_z;
  end

  // ---------------- add path: edges, cross products, write ----------------
  logic signed [CW:0]       ab_q [3];
  logic signed [CW:0]       ac_q [3];
  logic signed [2*CW+1:0]   xm_q [6];
  tbot_pkg::tri_entry_t     wr_entry;
  tbot_pkg::tri_entry_t     rd_entry;
  logic [tbot_pkg::EntryW-1:0] rd_raw;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ab_q[k] <= (CW+1)'(pb[k]) - (CW+1)'(pa[k]);
      ac_q[k] <= (CW+1)'(pc[k]) - (CW+1)'(pa[k]);
    end
    xm_q[0] <= (2*CW+2)'(ac_q[1]) * (2*CW+2)'(ab_q[2]);
    xm_q[1] <= (2*CW+2)'(ac_q[2]) * (2*CW+2)'(ab_q[1]);
    xm_q[2] <= (2*CW+2)'(ac_q[2]) * (2*CW+2)'(ab_q[0]);
    xm_q[3] <= (2*CW+2)'(ac_q[0]) * (2*CW+2)'(ab_q[2]);
    xm_q[4] <= (2*CW+2)'(ac_q[0]) * (2*CW+2)'(ab_q[1]);
    xm_q[5] <= (2*CW+2)'(ac_q[1]) * (2*CW+2)'(ab_q[0]);
  end

  always_comb begin
    logic signed [CW-1:0] lo, hi;
    for (int k = 0; k < 3; k++) begin
      lo = pa[k];
      hi = pa[k];
      if (pb[k] < lo) lo = pb[k];
      if (pc[k] < lo) lo = pc[k];
      if (pb[k] > hi) hi = pb[k];
      if (pc[k] > hi) hi = pc[k];
      wr_entry.a[k]  = pa[k];
      wr_entry.b[k]  = pb[k];
      wr_entry.c[k]  = pc[k];
      wr_entry.lo[k] = lo;
      wr_entry.hi[k] = hi;
    end
    wr_entry.nrm[0] = NW'(xm_q[0]) - NW'(xm_q[1]);
    wr_entry.nrm[1] = NW'(xm_q[2]) - NW'(xm_q[3]);
    wr_entry.nrm[2] = NW'(xm_q[4]) - NW'(xm_q[5]);
  end

  tbot_ram #(
    .Width (tbot_pkg::EntryW),
    .Depth (tbot_pkg::TriangleDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.addr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.addr),
    .rdata_o (rd_raw)
  );

  assign rd_entry = tbot_pkg::tri_entry_t'(rd_raw);

  // ---------------- query pipeline ----------------
  logic v0_q, v1_q, v2_q, v3_q;
  logic bnd1_q, bnd2_q, bnd3_q;
  logic hit_q;

  // stage 1: relative corners, bounds test, plane offsets, edges
  logic signed [CW:0]   rel_q [3][3];   // [corner][axis]
  logic signed [CW+1:0] ap_q [3];
  logic signed [CW+1:0] an_q [3];
  logic signed [CW:0]   f_q  [3][3];    // [edge][axis]
  logic        [CW:0]   fm_q [3][3];
  logic signed [NW-1:0] nrm_q [3];

  // stage 2: products
  logic signed [NW+CW+1:0] pd_q [3];
  logic signed [NW+CW+1:0] pn_q [3];
  logic signed [2*CW+1:0]  m1_q [3][3][3];  // [axis i][edge j][corner]
  logic signed [2*CW+1:0]  m2_q [3][3][3];
  logic        [2*CW-1:0]  r1_q [3][3];
  logic        [2*CW-1:0]  r2_q [3][3];

  // stage 3: sums
  logic signed [NW+CW+3:0] dp_q, dn_q;
  logic signed [2*CW+2:0]  pr_q [3][3][3];
  logic        [2*CW:0]    r_q  [3][3];

  logic pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.rd_en;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.clr_hit) begin
        hit_q <= 1'b0;
      end else if (v3_q && pass) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] sa, sb, sc, slo, shi, ct;
    logic signed [CW+1:0] h18, ph, lor, hir;
    logic signed [CW:0]   e0, e1, e2;
    logic                 ok;
    ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      sa  = $signed(rd_entry.a[k]);
      sb  = $signed(rd_entry.b[k]);
      sc  = $signed(rd_entry.c[k]);
      slo = $signed(rd_entry.lo[k]);
      shi = $signed(rd_entry.hi[k]);
      ct  = pa[k];
      h18 = $signed({3'b000, hv[k]});
      lor = (CW+2)'(slo) - (CW+2)'(ct);
      hir = (CW+2)'(shi) - (CW+2)'(ct);
      if (lor > h18 || hir < -h18) ok = 1'b0;
      ph = rd_entry.nrm[k][NW-1] ? -h18 : h18;
      ap_q[k] <= (CW+2)'(sa) - (CW+2)'(ct) - ph;
      an_q[k] <= (CW+2)'(sa) - (CW+2)'(ct) + ph;
      rel_q[0][k] <= (CW+1)'(sa) - (CW+1)'(ct);
      rel_q[1][k] <= (CW+1)'(sb) - (CW+1)'(ct);
      rel_q[2][k] <= (CW+1)'(sc) - (CW+1)'(ct);
      e0 = (CW+1)'(sb) - (CW+1)'(sa);
      e1 = (CW+1)'(sc) - (CW+1)'(sb);
      e2 = (CW+1)'(sa) - (CW+1)'(sc);
      f_q[0][k] <= e0;
      f_q[1][k] <= e1;
      f_q[2][k] <= e2;
      // edge magnitudes travel with the edges into stage 2
      fm_q[0][k] <= e0[CW] ? (CW+1)'(-e0) : (CW+1)'(e0);
      fm_q[1][k] <= e1[CW] ? (CW+1)'(-e1) : (CW+1)'(e1);
      fm_q[2][k] <= e2[CW] ? (CW+1)'(-e2) : (CW+1)'(e2);
      nrm_q[k] <= $signed(rd_entry.nrm[k]);
    end
    bnd1_q <= ok;

    // stage 2
    for (int k = 0; k < 3; k++) begin
      pd_q[k] <= (NW+CW+2)'(nrm_q[k]) * (NW+CW+2)'(ap_q[k]);
      pn_q[k] <= (NW+CW+2)'(nrm_q[k]) * (NW+CW+2)'(an_q[k]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int p = 0; p < 3; p++) begin
          m1_q[i][j][p] <= (2*CW+2)'(f_q[j][tbot_pkg::nxt(tbot_pkg::nxt(i))])
                         * (2*CW+2)'(rel_q[p][tbot_pkg::nxt(i)]);
          m2_q[i][j][p] <= (2*CW+2)'(f_q[j][tbot_pkg::nxt(i)])
                         * (2*CW+2)'(rel_q[p][tbot_pkg::nxt(tbot_pkg::nxt(i))]);
        end
        r1_q[i][j] <= (2*CW)'(hv[tbot_pkg::nxt(i)])
                    * (2*CW)'(fm_q[j][tbot_pkg::nxt(tbot_pkg::nxt(i))]);
        r2_q[i][j] <= (2*CW)'(hv[tbot_pkg::nxt(tbot_pkg::nxt(i))])
                    * (2*CW)'(fm_q[j][tbot_pkg::nxt(i)]);
      end
    end
    bnd2_q <= bnd1_q;

    // stage 3
    dp_q <= (NW+CW+4)'(pd_q[0]) + (NW+CW+4)'(pd_q[1]) + (NW+CW+4)'(pd_q[2]);
    dn_q <= (NW+CW+4)'(pn_q[0]) + (NW+CW+4)'(pn_q[1]) + (NW+CW+4)'(pn_q[2]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int p = 0; p < 3; p++) begin
          pr_q[i][j][p] <= (2*CW+3)'(m2_q[i][j][p]) - (2*CW+3)'(m1_q[i][j][p]);
        end
        r_q[i][j] <= (2*CW+1)'(r1_q[i][j]) + (2*CW+1)'(r2_q[i][j]);
      end
    end
    bnd3_q <= bnd2_q;
  end

  // stage 4: decisions
  always_comb begin
    logic signed [2*CW+3:0] rs, pv;
    logic                   all_gt, all_lt;
    logic                   dp_neg, dp_pos, dn_neg, dn_pos;
    logic                   ok;
    dp_neg = dp_q[NW+CW+3];
    dn_neg = dn_q[NW+CW+3];
    dp_pos = !dp_neg && (dp_q != '0);
    dn_pos = !dn_neg && (dn_q != '0);
    ok = bnd3_q;
    // plane misses when both extreme corners fall on one side, or both touch it
    if ((dp_neg && dn_neg) || (dp_pos && dn_pos) || (!dp_neg && !dp_pos && !dn_neg && !dn_pos))
      ok = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rs = $signed({3'b000, r_q[i][j]});
        all_gt = 1'b1;
        all_lt = 1'b1;
        for (int p = 0; p < 3; p++) begin
          pv = (2*CW+4)'(pr_q[i][j][p]);
          if (!(pv > rs)) all_gt = 1'b0;
          if (!(pv < -rs)) all_lt = 1'b0;
        end
        if (all_gt || all_lt) ok = 1'b0;
      end
    end
    pass = ok;
  end

  assign sts_o.busy = v0_q | v1_q | v2_q | v3_q;
  assign sts_o.hit  = hit_q;

endmodule

// File: sv/tbot_ctrl.sv
module tbot_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tbot_pkg::out_word_t  out_word_o,
  output tbot_pkg::cmd_t       cmd_o,
  input  tbot_pkg::sts_t       sts_i
);

  localparam int unsigned CntW = tbot_pkg::CntW;
  localparam int unsigned AddrW = tbot_pkg::AddrW;

  typedef enum logic [2:0] {
    StIdle, StAdd1, StAdd2, StAdd3, StScan, StDrain, StDone
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q, scan_q;
  logic                qry_q, status_q;
  logic                out_valid_q;
  tbot_pkg::out_word_t out_q;
  logic                accept, out_free;

  assign accept   = (state_q == StIdle) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.load    = accept;
    cmd_o.clr_hit = accept && (opcode_i == tbot_pkg::OpQuery);
    cmd_o.wr_en   = (state_q == StAdd3);
    cmd_o.rd_en   = (state_q == StScan);
    cmd_o.addr    = (state_q == StAdd3) ? count_q[AddrW-1:0] : scan_q[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      scan_q      <= '0;
      qry_q       <= 1'b0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // in StDone the output register is reloaded below instead
      if (out_valid_q && !out_stall_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            qry_q    <= 1'b0;
            status_q <= 1'b0;
            state_q  <= StDone;
            case (opcode_i)
              tbot_pkg::OpClear: count_q <= '0;
              tbot_pkg::OpAdd: begin
                if (count_q == CntW'(tbot_pkg::TriangleDepth)) begin
                  status_q <= 1'b1;
                end else begin
                  state_q <= StAdd1;
                end
              end
              tbot_pkg::OpQuery: begin
                qry_q  <= 1'b1;
                scan_q <= '0;
                if (count_q != '0) state_q <= StScan;
              end
              default: ;
            endcase
          end
        end
        StAdd1: state_q <= StAdd2;
        StAdd2: state_q <= StAdd3;
        StAdd3: begin
          count_q <= count_q + CntW'(1);
          state_q <= StDone;
        end
        StScan: begin
          if ((scan_q + CntW'(1)) == count_q) begin
            state_q <= StDrain;
          end else begin
            scan_q <= scan_q + CntW'(1);
          end
        end
        StDrain: begin
          if (!sts_i.busy) state_q <= StDone;
        end
        StDone: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_q.hit            <= qry_q & sts_i.hit;
            out_q.status         <= status_q;
            out_q.triangle_count <= tbot_pkg::CountOutW'(count_q);
            state_q              <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: sv/tbot_check.sv
`include "triangle_box_overlap_table_assert.svh"

module tbot_check (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tbot_pkg::out_word_t out_word_o
);

  `TBOT_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))
  `TBOT_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `TBOT_ASSERT_IMP(a_hit_xor_status, out_valid_o, !(out_word_o.hit && out_word_o.status))
  `TBOT_ASSERT_IMP(a_drop_when_full, out_valid_o && out_word_o.status,
    out_word_o.triangle_count == tbot_pkg::CountOutW'(tbot_pkg::TriangleDepth))

endmodule

bind triangle_box_overlap_table tbot_check u_check (.*);
